[hdl/mtm_pkg.sv]
// ----------------------------------------------------------------------------
// mtm_pkg
// shared types, constants, controller lookup and channel remap for the converter
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int unsigned TickBits = 32;

  localparam logic [7:0] ScoreEndByte = 8'h60;
  localparam logic [3:0] StatusNote   = 4'h9;
  localparam logic [3:0] StatusCtrl   = 4'hB;
  localparam logic [3:0] StatusProg   = 4'hC;
  localparam logic [3:0] StatusWheel  = 4'hE;
  localparam logic [2:0] MaxEventType = 3'd4;
  localparam logic [7:0] SysCtrlLow   = 8'd10;
  localparam logic [7:0] SysCtrlHigh  = 8'd14;
  localparam logic [7:0] CtrlLimit    = 8'd10;

  typedef enum logic [1:0] {
    KindMsg = 2'd0,
    KindEnd = 2'd1,
    KindErr = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone       = 3'd0,
    ErrTruncated  = 3'd1,
    ErrBadType    = 3'd2,
    ErrBadCtrl    = 3'd3,
    ErrNoDelta    = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    EvRelease = 3'd0,
    EvPlay    = 3'd1,
    EvWheel   = 3'd2,
    EvSystem  = 3'd3,
    EvControl = 3'd4
  } ev_type_e;

  typedef struct packed {
    logic       action;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick_time;
    logic [7:0]  midi_status;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  data_count;
    logic [2:0]  error_code;
  } out_item_t;

  function automatic logic [7:0] ctrl_map(input logic [3:0] idx);
    logic [7:0] val;
    unique case (idx)
      4'd0:    val = 8'd0;
      4'd1:    val = 8'd0;
      4'd2:    val = 8'd1;
      4'd3:    val = 8'd7;
      4'd4:    val = 8'd10;
      4'd5:    val = 8'd11;
      4'd6:    val = 8'd91;
      4'd7:    val = 8'd93;
      4'd8:    val = 8'd64;
      4'd9:    val = 8'd67;
      4'd10:   val = 8'd120;
      4'd11:   val = 8'd123;
      4'd12:   val = 8'd126;
      4'd13:   val = 8'd127;
      4'd14:   val = 8'd121;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

  function automatic logic [3:0] remap_chan(input logic [3:0] mus_ch);
    logic [3:0] ch;
    if (mus_ch == 4'd15) begin
      ch = 4'd9;
    end else if (mus_ch >= 4'd9) begin
      ch = mus_ch + 4'd1;
    end else begin
      ch = mus_ch;
    end
    return ch;
  endfunction

endpackage

[hdl/mtm_parser.sv]
// ----------------------------------------------------------------------------
// mtm_parser
// per-byte event parser: phase update, velocity store, tick count, result
// ----------------------------------------------------------------------------
module mtm_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  mtm_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output mtm_pkg::out_item_t res_o
);
  import mtm_pkg::*;

  localparam logic [2:0] PhEvent      = 3'd0;
  localparam logic [2:0] PhOperand    = 3'd1;
  localparam logic [2:0] PhVelocity   = 3'd2;
  localparam logic [2:0] PhCtrl       = 3'd3;
  localparam logic [2:0] PhDeltaFirst = 3'd4;
  localparam logic [2:0] PhDeltaMore  = 3'd5;

  localparam logic [1:0] FinRunning = 2'd0;
  localparam logic [1:0] FinEnded   = 2'd1;
  localparam logic [1:0] FinError   = 2'd2;

  logic [2:0]          phase_q, phase_d;
  logic [7:0]          event_q, event_d;
  logic [7:0]          operand_q, operand_d;
  logic [7:0]          vel_q [16];
  logic [TickBits-1:0] tick_q, tick_d;
  logic [TickBits-1:0] delta_q, delta_d;
  logic [1:0]          fin_q, fin_d;

  logic                vel_we;
  logic [3:0]          ch;
  logic [7:0]          b;
  logic                is_end;
  logic [TickBits-1:0] delta_new;

  logic       do_emit, do_end, do_err;
  logic [7:0] st, d1, d2;
  logic [1:0] cnt;
  err_e       code;

  assign ch        = remap_chan(event_q[3:0]);
  assign b         = item_i.stream_byte;
  assign is_end    = item_i.action;
  assign delta_new = {delta_q[TickBits-8:0], b[6:0]};

  always_comb begin
    phase_d   = phase_q;
    event_d   = event_q;
    operand_d = operand_q;
    tick_d    = tick_q;
    delta_d   = delta_q;
    fin_d     = fin_q;
    vel_we    = 1'b0;
    do_emit   = 1'b0;
    do_end    = 1'b0;
    do_err    = 1'b0;
    st        = 8'd0;
    d1        = 8'd0;
    d2        = 8'd0;
    cnt       = 2'd2;
    code      = ErrNone;

    if (valid_i && fin_q == FinRunning) begin
      unique case (phase_q)
        PhEvent: begin
          if (is_end || b == ScoreEndByte) begin
            do_end = 1'b1;
          end else if (b[6:4] > MaxEventType) begin
            do_err = 1'b1;
            code   = ErrBadType;
          end else begin
            event_d = b;
            phase_d = PhOperand;
          end
        end
        PhOperand: begin
          if (is_end) begin
            do_err = 1'b1;
            code   = ErrTruncated;
          end else begin
            unique case (event_q[6:4])
              EvRelease: begin
                do_emit = 1'b1;
                st      = {StatusNote, ch};
                d1      = b;
              end
              EvPlay: begin
                if (b[7]) begin
                  operand_d = {1'b0, b[6:0]};
                  phase_d   = PhVelocity;
                end else begin
                  do_emit = 1'b1;
                  st      = {StatusNote, ch};
                  d1      = b;
                  d2      = vel_q[ch];
                end
              end
              EvWheel: begin
                do_emit = 1'b1;
                st      = {StatusWheel, ch};
                d1      = {1'b0, b[0], 6'd0};
                d2      = {1'b0, b[7:1]};
              end
              EvSystem: begin
                if (b < SysCtrlLow || b > SysCtrlHigh) begin
                  do_err = 1'b1;
                  code   = ErrBadCtrl;
                end else begin
                  do_emit = 1'b1;
                  st      = {StatusCtrl, ch};
                  d1      = ctrl_map(b[3:0]);
                  d2      = 8'd1;
                end
              end
              default: begin
                if (b >= CtrlLimit) begin
                  do_err = 1'b1;
                  code   = ErrBadCtrl;
                end else begin
                  operand_d = b;
                  phase_d   = PhCtrl;
                end
              end
            endcase
          end
        end
        PhVelocity: begin
          if (is_end) begin
            do_err = 1'b1;
            code   = ErrTruncated;
          end else begin
            vel_we  = 1'b1;
            do_emit = 1'b1;
            st      = {StatusNote, ch};
            d1      = operand_q;
            d2      = b;
          end
        end
        PhCtrl: begin
          if (is_end) begin
            do_err = 1'b1;
            code   = ErrTruncated;
          end else if (operand_q == 8'd0) begin
            do_emit = 1'b1;
            st      = {StatusProg, ch};
            d1      = b;
            cnt     = 2'd1;
          end else begin
            do_emit = 1'b1;
            st      = {StatusCtrl, ch};
            d1      = ctrl_map(operand_q[3:0]);
            d2      = b;
          end
        end
        PhDeltaFirst, PhDeltaMore: begin
          if (is_end) begin
            if (phase_q == PhDeltaFirst) begin
              do_err = 1'b1;
              code   = ErrNoDelta;
            end else begin
              tick_d = tick_q + delta_q;
              do_end = 1'b1;
            end
          end else if (b[7]) begin
            delta_d = delta_new;
            phase_d = PhDeltaMore;
          end else begin
            tick_d  = tick_q + delta_new;
            delta_d = '0;
            phase_d = PhEvent;
          end
        end
        default: begin
          phase_d = PhEvent;
        end
      endcase

      if (do_emit) begin
        if (event_q[7]) begin
          delta_d = '0;
          phase_d = PhDeltaFirst;
        end else begin
          phase_d = PhEvent;
        end
      end
      if (do_end) begin
        fin_d = FinEnded;
      end
      if (do_err) begin
        fin_d = FinError;
      end
    end
  end

  always_comb begin
    res_valid_o       = do_emit | do_end | do_err;
    res_o.tick_time   = 32'(tick_d);
    res_o.midi_status = st;
    res_o.first_data  = d1;
    res_o.second_data = d2;
    res_o.data_count  = do_emit ? cnt : 2'd0;
    res_o.error_code  = do_err ? code : ErrNone;
    if (do_err) begin
      res_o.kind = KindErr;
    end else if (do_end) begin
      res_o.kind = KindEnd;
    end else begin
      res_o.kind = KindMsg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhEvent;
      event_q   <= 8'd0;
      operand_q <= 8'd0;
      tick_q    <= '0;
      delta_q   <= '0;
      fin_q     <= FinRunning;
      for (int i = 0; i < 16; i++) begin
        vel_q[i] <= 8'd0;
      end
    end else begin
      phase_q   <= phase_d;
      event_q   <= event_d;
      operand_q <= operand_d;
      tick_q    <= tick_d;
      delta_q   <= delta_d;
      fin_q     <= fin_d;
      if (vel_we) begin
        vel_q[ch] <= b;
      end
    end
  end

endmodule

[hdl/mtm_out_buf.sv]
// ----------------------------------------------------------------------------
// mtm_out_buf
// two-entry result register with skid slot, registered stall toward parser
// ----------------------------------------------------------------------------
module mtm_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mtm_pkg::out_item_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output mtm_pkg::out_item_t data_o
);
  import mtm_pkg::*;

  logic      out_v_q, out_v_d;
  logic      skid_v_q, skid_v_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      room;

  assign room = !out_v_q || !stall_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (room) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = data_i;
        out_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

[hdl/mus_to_midi_event_converter.sv]
// ----------------------------------------------------------------------------
// mus_to_midi_event_converter
// converts a MUS event byte stream into timed MIDI channel messages
// ----------------------------------------------------------------------------
// Takes one stream byte (or the end item) per clock cycle while in_stall_o
// is low. Each byte is parsed in the cycle it is accepted, and any resulting
// message goes through a registered two-entry result buffer to the output.
// in_stall_o rises only when the output side has held a result and a second
// one has backed up into the skid slot; it is a register, not a path from
// out_stall_i. After end of track or an error the block ignores all input
// until reset.
module mus_to_midi_event_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mtm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mtm_pkg::out_item_t out_item_o
);
  import mtm_pkg::*;

  logic      in_accept;
  logic      res_valid;
  out_item_t res;
  logic      buf_full;

  assign in_accept  = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  mtm_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_accept),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_item_o)
  );

endmodule

[bench/mus_to_midi_event_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mus_to_midi_event_converter_tb
// self-checking bench for the MUS to MIDI event converter
// ----------------------------------------------------------------------------
// Feeds well-formed MUS event streams (all event types, all channels, short
// and long delta times, tick wrap) under several sender and receiver idle
// mixes, a long receiver hold-off and a full drain pause. The stream is then
// closed by one randomly chosen ending (score end, end request, bad type,
// truncation, bad controller, missing or cut delta), followed by requests the
// block must ignore. Every result is checked field by field against a
// behavioral converter kept in the bench.
// ----------------------------------------------------------------------------
module mus_to_midi_event_converter_tb;
  import mtm_pkg::*;

  typedef enum logic [2:0] {
    ScanEvent, ScanOperand, ScanVelocity, ScanCtrl, ScanDeltaFirst, ScanDeltaMore
  } scan_e;

  typedef enum logic [1:0] {
    TrackRunning, TrackEnded, TrackFailed
  } track_e;

  typedef enum int {
    StopScoreEnd, StopIdleEnd, StopBadType, StopTruncated, StopBadCtrl,
    StopNoDelta, StopCutDelta
  } stop_e;

  // midi controller numbers for mus controller indexes 0..14
  localparam logic [14:0][7:0] CtrlNumber = {
    8'd121, 8'd127, 8'd126, 8'd123, 8'd120, 8'd67, 8'd64, 8'd93,
    8'd91, 8'd11, 8'd10, 8'd7, 8'd1, 8'd0, 8'd0
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  mus_to_midi_event_converter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // converter state
  scan_e       scan_phase;
  logic [7:0]  cur_event;
  logic [7:0]  cur_operand;
  logic [7:0]  chan_vel [16];
  logic [31:0] abs_tick;
  logic [31:0] pending_delta;
  track_e      track_state;
  out_item_t   staged_msg;
  logic        staged_valid;
  out_item_t   expected_msgs [$];

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int requests_sent;
  int results_checked;
  int n_msg;
  int n_end;
  int n_err;
  int fail_count;
  string stop_label;
  out_item_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [3:0] midi_channel(input logic [3:0] mus_ch);
    if (mus_ch == 4'd15) return 4'd9;
    return (mus_ch >= 4'd9) ? mus_ch + 4'd1 : mus_ch;
  endfunction

  task automatic stage_message(input logic [3:0] status_hi, input logic [3:0] ch,
                               input logic [7:0] d1, input logic [7:0] d2,
                               input logic [1:0] cnt);
    staged_msg.kind        = KindMsg;
    staged_msg.midi_status = {status_hi, ch};
    staged_msg.first_data  = d1;
    staged_msg.second_data = d2;
    staged_msg.data_count  = cnt;
    staged_valid           = 1'b1;
    pending_delta          = '0;
    scan_phase             = cur_event[7] ? ScanDeltaFirst : ScanEvent;
  endtask

  task automatic stage_stop(input kind_e k, input err_e code);
    track_state           = (k == KindEnd) ? TrackEnded : TrackFailed;
    staged_msg.kind       = k;
    staged_msg.error_code = code;
    staged_valid          = 1'b1;
  endtask

  task automatic convert_request(input in_item_t req);
    logic [7:0] b;
    logic [3:0] ch;
    b            = req.stream_byte;
    ch           = midi_channel(cur_event[3:0]);
    staged_msg   = '0;
    staged_valid = 1'b0;
    if (track_state == TrackRunning) begin
      case (scan_phase)
        ScanEvent: begin
          if (req.action || b == ScoreEndByte) begin
            stage_stop(KindEnd, ErrNone);
          end else if (b[6:4] > MaxEventType) begin
            stage_stop(KindErr, ErrBadType);
          end else begin
            cur_event  = b;
            scan_phase = ScanOperand;
          end
        end
        ScanOperand: begin
          if (req.action) begin
            stage_stop(KindErr, ErrTruncated);
          end else begin
            case (cur_event[6:4])
              EvRelease: stage_message(StatusNote, ch, b, 8'd0, 2'd2);
              EvPlay: begin
                if (b[7]) begin
                  cur_operand = {1'b0, b[6:0]};
                  scan_phase  = ScanVelocity;
                end else begin
                  stage_message(StatusNote, ch, b, chan_vel[ch], 2'd2);
                end
              end
              EvWheel: begin
                stage_message(StatusWheel, ch, {1'b0, b[0], 6'd0}, {1'b0, b[7:1]}, 2'd2);
              end
              EvSystem: begin
                if (b < SysCtrlLow || b > SysCtrlHigh) begin
                  stage_stop(KindErr, ErrBadCtrl);
                end else begin
                  stage_message(StatusCtrl, ch, CtrlNumber[b[3:0]], 8'd1, 2'd2);
                end
              end
              default: begin
                if (b >= CtrlLimit) begin
                  stage_stop(KindErr, ErrBadCtrl);
                end else begin
                  cur_operand = b;
                  scan_phase  = ScanCtrl;
                end
              end
            endcase
          end
        end
        ScanVelocity: begin
          if (req.action) begin
            stage_stop(KindErr, ErrTruncated);
          end else begin
            chan_vel[ch] = b;
            stage_message(StatusNote, ch, cur_operand, b, 2'd2);
          end
        end
        ScanCtrl: begin
          if (req.action) begin
            stage_stop(KindErr, ErrTruncated);
          end else if (cur_operand == 8'd0) begin
            stage_message(StatusProg, ch, b, 8'd0, 2'd1);
          end else begin
            stage_message(StatusCtrl, ch, CtrlNumber[cur_operand[3:0]], b, 2'd2);
          end
        end
        default: begin
          if (req.action) begin
            if (scan_phase == ScanDeltaFirst) begin
              stage_stop(KindErr, ErrNoDelta);
            end else begin
              abs_tick = abs_tick + pending_delta;
              stage_stop(KindEnd, ErrNone);
            end
          end else begin
            pending_delta = {pending_delta[24:0], b[6:0]};
            if (b[7]) begin
              scan_phase = ScanDeltaMore;
            end else begin
              abs_tick      = abs_tick + pending_delta;
              pending_delta = '0;
              scan_phase    = ScanEvent;
            end
          end
        end
      endcase
    end
    if (staged_valid) begin
      staged_msg.tick_time = abs_tick;
      expected_msgs.push_back(staged_msg);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    fail_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_val, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      case (out_item.kind)
        KindMsg: n_msg++;
        KindEnd: n_end++;
        default: n_err++;
      endcase
      if (expected_msgs.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(out_item.kind), '0);
      end else begin
        want = expected_msgs.pop_front();
        if (out_item.kind != want.kind)
          report_mismatch("kind", 32'(out_item.kind), 32'(want.kind));
        if (out_item.tick_time != want.tick_time)
          report_mismatch("tick_time", out_item.tick_time, want.tick_time);
        if (out_item.midi_status != want.midi_status)
          report_mismatch("midi_status", 32'(out_item.midi_status), 32'(want.midi_status));
        if (out_item.first_data != want.first_data)
          report_mismatch("first_data", 32'(out_item.first_data), 32'(want.first_data));
        if (out_item.second_data != want.second_data)
          report_mismatch("second_data", 32'(out_item.second_data), 32'(want.second_data));
        if (out_item.data_count != want.data_count)
          report_mismatch("data_count", 32'(out_item.data_count), 32'(want.data_count));
        if (out_item.error_code != want.error_code)
          report_mismatch("error_code", 32'(out_item.error_code), 32'(want.error_code));
      end
    end
  end

  // receiver stall, with a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(input in_item_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    convert_request(req);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t req;
    req.action      = 1'b0;
    req.stream_byte = b;
    send_item(req);
  endtask

  task automatic send_end();
    in_item_t req;
    req.action      = 1'b1;
    req.stream_byte = 8'($urandom_range(0, 255));
    send_item(req);
  endtask

  task automatic pause_sender();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk);
  endtask

  task automatic send_delta(input int len);
    for (int i = 0; i < len - 1; i++) send_byte({1'b1, 7'($urandom_range(0, 127))});
    send_byte({1'b0, 7'($urandom_range(0, 127))});
  endtask

  task automatic send_random_event();
    logic [7:0] ev;
    logic [7:0] op;
    int pick;
    ev[7]   = 1'($urandom_range(0, 1));
    ev[6:4] = 3'($urandom_range(0, 4));
    ev[3:0] = 4'($urandom_range(0, 15));
    op      = 8'($urandom_range(0, 255));
    send_byte(ev);
    case (ev[6:4])
      EvPlay: begin
        send_byte(op);
        if (op[7]) send_byte(8'($urandom_range(0, 255)));
      end
      EvSystem: send_byte(8'($urandom_range(10, 14)));
      EvControl: begin
        send_byte(8'($urandom_range(0, 9)));
        send_byte(op);
      end
      default: send_byte(op);
    endcase
    if (ev[7]) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) send_delta(1);
      else if (pick < 90) send_delta($urandom_range(2, 3));
      else send_delta($urandom_range(4, 7));
    end
  endtask

  task automatic test_directed_messages();
    send_byte(8'h80); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h1F); send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'h1F); send_byte(8'h40);
    send_byte(8'h29); send_byte(8'hFF);
    send_byte(8'h3E); send_byte(8'h0E);
    send_byte(8'h30); send_byte(8'h0A);
    // program change, then a delta long enough to set every tick bit
    send_byte(8'hC8); send_byte(8'h00); send_byte(8'hFF);
    repeat (5) send_byte(8'hFF);
    send_byte(8'h7F);
    // tick wraps past zero
    send_byte(8'hC3); send_byte(8'h09); send_byte(8'h80); send_byte(8'h02);
    send_byte(8'h01); send_byte(8'hFF);
    pause_sender();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_mix, input int count);
    int start;
    send_idle_pct = idle_pct;
    stall_pct     = stall_mix;
    start         = requests_sent;
    while (requests_sent < start + count) send_random_event();
  endtask

  task automatic test_receiver_hold();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 80;
    repeat (30) send_random_event();
    pause_sender();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    stall_pct     = 30;
    repeat (8) send_random_event();
    pause_sender();
    repeat (8) send_random_event();
  endtask

  task automatic test_stream_close();
    stop_e stop_case;
    logic [7:0] ev;
    in_item_t req;
    send_idle_pct = 20;
    stall_pct     = 20;
    stop_case     = stop_e'($urandom_range(0, 6));
    case (stop_case)
      StopScoreEnd: begin
        stop_label = "score end byte";
        send_byte(ScoreEndByte);
      end
      StopIdleEnd: begin
        stop_label = "end request between events";
        send_end();
      end
      StopBadType: begin
        stop_label = "bad event type";
        do begin
          ev = {1'($urandom_range(0, 1)), 3'($urandom_range(5, 7)),
                4'($urandom_range(0, 15))};
        end while (ev == ScoreEndByte);
        send_byte(ev);
      end
      StopTruncated: begin
        stop_label = "truncated event";
        case ($urandom_range(0, 2))
          0: begin
            send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 4)),
                       4'($urandom_range(0, 15))});
          end
          1: begin
            send_byte({4'h1, 4'($urandom_range(0, 15))});
            send_byte({1'b1, 7'($urandom_range(0, 127))});
          end
          default: begin
            send_byte({4'h4, 4'($urandom_range(0, 15))});
            send_byte(8'($urandom_range(0, 9)));
          end
        endcase
        send_end();
      end
      StopBadCtrl: begin
        stop_label = "bad controller";
        if ($urandom_range(0, 1)) begin
          send_byte({4'h3, 4'($urandom_range(0, 15))});
          send_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(15, 255)));
        end else begin
          send_byte({4'h4, 4'($urandom_range(0, 15))});
          send_byte(8'($urandom_range(10, 255)));
        end
      end
      StopNoDelta: begin
        stop_label = "missing delta";
        send_byte({4'h8, 4'($urandom_range(0, 15))});
        send_byte(8'($urandom_range(0, 255)));
        send_end();
      end
      default: begin
        stop_label = "cut delta";
        send_byte({4'hA, 4'($urandom_range(0, 15))});
        send_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4)) send_byte({1'b1, 7'($urandom_range(0, 127))});
        send_end();
      end
    endcase
    // everything after the close must be ignored
    repeat (12) begin
      req.action      = 1'($urandom_range(0, 1));
      req.stream_byte = 8'($urandom_range(0, 255));
      send_item(req);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_item         = '0;
    out_stall       = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_left       = 0;
    requests_sent   = 0;
    results_checked = 0;
    n_msg           = 0;
    n_end           = 0;
    n_err           = 0;
    fail_count      = 0;
    stop_label      = "none";
    scan_phase      = ScanEvent;
    cur_event       = '0;
    cur_operand     = '0;
    for (int i = 0; i < 16; i++) chan_vel[i] = '0;
    abs_tick        = '0;
    pending_delta   = '0;
    track_state     = TrackRunning;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed_messages();
    test_random_traffic(0, 0, 110);
    test_random_traffic(69, 0, 110);
    test_random_traffic(0, 69, 110);
    test_random_traffic(10, 10, 110);
    test_receiver_hold();
    test_drain_pause();
    test_stream_close();

    stall_pct = 0;
    pause_sender();
    repeat (20) @(posedge clk);
    $display("summary: %0d requests, %0d results checked (%0d messages, %0d ends, %0d errors)",
             requests_sent, results_checked, n_msg, n_end, n_err);
    $display("summary: stream closed by %s at tick %0h", stop_label, abs_tick);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
